// ===== hdl/ata_seq_pkg.sv =====
// shared types, codes and sizes of the ata pio sector sequencer
package ata_seq_pkg;

  localparam int SECTOR_WORDS = 256;
  localparam int MAX_SECTORS  = 256;
  localparam int WORD_IDX_W   = $clog2(SECTOR_WORDS);
  localparam int SECT_CNT_W   = $clog2(MAX_SECTORS + 1);
  localparam int TICK_W       = 10;
  localparam int LBA_W        = 28;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // input operation codes
  typedef enum logic [2:0] {
    OP_START_RD = 3'd0,
    OP_START_WR = 3'd1,
    OP_STATUS   = 3'd2,
    OP_RD_WORD  = 3'd3,
    OP_WR_WORD  = 3'd4,
    OP_TICK     = 3'd5
  } op_t;

  // result bus actions
  typedef enum logic [2:0] {
    ACT_REG_WR  = 3'd0,
    ACT_POLL    = 3'd1,
    ACT_TO_DEV  = 3'd2,
    ACT_TO_HOST = 3'd3,
    ACT_DONE    = 3'd4
  } act_t;

  // task file register indexes
  typedef enum logic [2:0] {
    REG_NONE     = 3'd0,
    REG_SEC_CNT  = 3'd2,
    REG_LBA_LOW  = 3'd3,
    REG_LBA_MID  = 3'd4,
    REG_LBA_HIGH = 3'd5,
    REG_DEVICE   = 3'd6,
    REG_CMD      = 3'd7
  } reg_sel_t;

  // completion codes
  typedef enum logic [1:0] {
    CC_OK        = 2'd0,
    CC_PARAM     = 2'd1,
    CC_NOT_READY = 2'd2,
    CC_FAULT     = 2'd3
  } cc_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEV_READY = 2'd0,
    CFG_READY_TO  = 2'd1,
    CFG_XFER_TO   = 2'd2,
    CFG_FINISH_TO = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] OPC_READ_PIO  = 8'h20;
  localparam logic [7:0] OPC_WRITE_PIO = 8'h30;
  localparam logic [3:0] DEV_LBA_HI    = 4'h4;

  // status bits
  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DRQ  = 3;
  localparam int ST_ERR  = 0;

  // work handed from front to back
  typedef enum logic [1:0] {
    JOB_DONE,
    JOB_POLL,
    JOB_TASKFILE,
    JOB_WORD
  } job_kind_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_POLL,
    TAIL_DONE
  } job_tail_t;

  typedef struct packed {
    job_kind_t         kind;
    job_tail_t         tail;
    cc_t               code;
    logic              is_write;
    logic [15:0]       word;
    logic [LBA_W-1:0]  lba;
    logic [7:0]        count;
  } job_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== hdl/ata_pio_sector_sequencer.sv =====
// top level of the ata pio lba28 sector sequencer
// Host-side ATA PIO sequencer for LBA28 multi-sector reads and writes. Every
// input item (start, status sample, data word or tick) is taken by the front
// end, which checks it against the current phase, updates the protocol state
// and, when the item causes bus work, places one job in a four-entry queue.
// The back end turns each job into its results at one per cycle while the
// receiver is ready, through a registered output stage: a data word gives
// one result (two at a sector boundary), a status sample that finds the
// drive ready gives seven (six task file writes and a status read request).
// Data words therefore stream at one per cycle in either direction while
// neither side stalls; the slower cases are the last word of a sector, whose
// two results hold its job at the queue head until both are out, and the
// task file burst, whose seven results do the same. in_ready drops only
// while the queue is full. Ticks, samples outside a status wait and words of
// the wrong direction give no result. Configuration writes are accepted in
// every cycle and must be made while the block is idle.
module ata_pio_sector_sequencer import ata_seq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_operation,
  input  logic [31:0]       in_sector_address,
  input  logic [8:0]        in_sector_count,
  input  logic [7:0]        in_status_byte,
  input  logic [15:0]       in_data_word,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_bus_action,
  output logic [2:0]        out_register_select,
  output logic [7:0]        out_register_value,
  output logic [15:0]       out_word_out,
  output logic [1:0]        out_completion_code,
  output logic              out_last,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [TICK_W-1:0] cfg_data
);

  // job path between the two halves
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t q_stat;

  // front: protocol state, timeouts, item checks
  ata_seq_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_sector_address (in_sector_address),
    .in_sector_count   (in_sector_count),
    .in_status_byte    (in_status_byte),
    .in_data_word      (in_data_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_stat            (q_stat),
    .push              (push),
    .job               (push_job)
  );

  // decouples item intake from result drain
  ata_seq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back: job expansion into the output register
  ata_seq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bus_action      (out_bus_action),
    .out_register_select (out_register_select),
    .out_register_value  (out_register_value),
    .out_word_out        (out_word_out),
    .out_completion_code (out_completion_code),
    .out_last            (out_last)
  );

  // a job is only half drained: its next result follows straight away
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("result burst broken before its last item");

  // completion codes only ride on completions
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_action != ACT_DONE |-> out_completion_code == CC_OK)
    else $error("completion code on a non-completion result");

  // register selects only ride on register writes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_action != ACT_REG_WR |-> out_register_select == REG_NONE)
    else $error("register select on a non-register result");

  // nothing is queued while the queue reports full
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("job pushed into a full queue");

endmodule

// ===== hdl/ata_seq_front.sv =====
// front end: accepts items, keeps the protocol state and queues work
module ata_seq_front import ata_seq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_operation,
  input  logic [31:0]           in_sector_address,
  input  logic [8:0]            in_sector_count,
  input  logic [7:0]            in_status_byte,
  input  logic [15:0]           in_data_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [TICK_W-1:0]     cfg_data,
  input  q_stat_t               q_stat,
  output logic                  push,
  output job_t                  job
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_READY,
    PH_DRQ,
    PH_XFER,
    PH_FINISH
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  is_write_r, is_write_nxt;
  logic [TICK_W-1:0]     timeout_r, timeout_nxt;
  logic [SECT_CNT_W-1:0] sectors_r, sectors_nxt;
  logic [WORD_IDX_W-1:0] word_idx_r, word_idx_nxt;
  logic [LBA_W-1:0]      lba_r, lba_nxt;
  logic [7:0]            count_r, count_nxt;

  logic                  dev_ready_r;
  logic [TICK_W-1:0]     ready_to_r, xfer_to_r, finish_to_r;

  logic                  accept;
  logic                  met;
  logic [SECT_CNT_W-1:0] sectors_dec;

  assign in_ready    = !q_stat.full;
  assign cfg_ready   = 1'b1;
  assign accept      = in_valid && in_ready;
  assign sectors_dec = sectors_r - SECT_CNT_W'(1);

  always_comb begin
    unique case (phase_r)
      PH_READY: met = !in_status_byte[ST_BSY] && in_status_byte[ST_DRDY];
      PH_DRQ:   met = !in_status_byte[ST_BSY] && in_status_byte[ST_DRQ];
      default:  met = !in_status_byte[ST_BSY];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    is_write_nxt = is_write_r;
    timeout_nxt  = timeout_r;
    sectors_nxt  = sectors_r;
    word_idx_nxt = word_idx_r;
    lba_nxt      = lba_r;
    count_nxt    = count_r;
    push         = 1'b0;
    job          = '0;
    job.is_write = is_write_r;
    job.lba      = lba_r;
    job.count    = count_r;
    if (accept) begin
      unique case (in_operation)
        OP_START_RD, OP_START_WR: begin
          if (phase_r == PH_IDLE) begin
            push = 1'b1;
            if (in_sector_count == '0 || in_sector_count > 9'(MAX_SECTORS) ||
                in_sector_address[31:LBA_W] != '0) begin
              job.kind = JOB_DONE;
              job.code = CC_PARAM;
            end else if (!dev_ready_r) begin
              job.kind = JOB_DONE;
              job.code = CC_NOT_READY;
            end else begin
              job.kind     = JOB_POLL;
              is_write_nxt = (in_operation == OP_START_WR);
              lba_nxt      = in_sector_address[LBA_W-1:0];
              count_nxt    = in_sector_count[7:0];
              sectors_nxt  = SECT_CNT_W'(in_sector_count);
              word_idx_nxt = '0;
              phase_nxt    = PH_READY;
              timeout_nxt  = ready_to_r;
            end
          end
        end
        OP_STATUS: begin
          if (phase_r == PH_READY || phase_r == PH_DRQ || phase_r == PH_FINISH) begin
            if (timeout_r == '0 || in_status_byte[ST_ERR]) begin
              push      = 1'b1;
              job.kind  = JOB_DONE;
              job.code  = CC_FAULT;
              phase_nxt = PH_IDLE;
            end else if (!met) begin
              push     = 1'b1;
              job.kind = JOB_POLL;
            end else if (phase_r == PH_READY) begin
              push        = 1'b1;
              job.kind    = JOB_TASKFILE;
              phase_nxt   = PH_DRQ;
              timeout_nxt = xfer_to_r;
            end else if (phase_r == PH_DRQ) begin
              phase_nxt    = PH_XFER;
              word_idx_nxt = '0;
            end else begin
              push      = 1'b1;
              job.kind  = JOB_DONE;
              job.code  = CC_OK;
              phase_nxt = PH_IDLE;
            end
          end
        end
        OP_RD_WORD, OP_WR_WORD: begin
          if (phase_r == PH_XFER && is_write_r == (in_operation == OP_WR_WORD)) begin
            push         = 1'b1;
            job.kind     = JOB_WORD;
            job.word     = in_data_word;
            job.tail     = TAIL_NONE;
            word_idx_nxt = word_idx_r + WORD_IDX_W'(1);
            if (word_idx_r == WORD_IDX_W'(SECTOR_WORDS - 1)) begin
              word_idx_nxt = '0;
              sectors_nxt  = sectors_dec;
              if (sectors_dec != '0) begin
                job.tail    = TAIL_POLL;
                phase_nxt   = PH_DRQ;
                timeout_nxt = xfer_to_r;
              end else if (is_write_r) begin
                job.tail    = TAIL_POLL;
                phase_nxt   = PH_FINISH;
                timeout_nxt = finish_to_r;
              end else begin
                job.tail  = TAIL_DONE;
                phase_nxt = PH_IDLE;
              end
            end
          end
        end
        OP_TICK: begin
          if (timeout_r != '0) timeout_nxt = timeout_r - TICK_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_write_r  <= 1'b0;
      timeout_r   <= '0;
      sectors_r   <= '0;
      word_idx_r  <= '0;
      lba_r       <= '0;
      count_r     <= '0;
      dev_ready_r <= 1'b0;
      ready_to_r  <= TICK_W'(100);
      xfer_to_r   <= TICK_W'(250);
      finish_to_r <= TICK_W'(100);
    end else begin
      phase_r    <= phase_nxt;
      is_write_r <= is_write_nxt;
      timeout_r  <= timeout_nxt;
      sectors_r  <= sectors_nxt;
      word_idx_r <= word_idx_nxt;
      lba_r      <= lba_nxt;
      count_r    <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DEV_READY: dev_ready_r <= cfg_data[0];
          CFG_READY_TO:  ready_to_r  <= cfg_data;
          CFG_XFER_TO:   xfer_to_r   <= cfg_data;
          CFG_FINISH_TO: finish_to_r <= cfg_data;
        endcase
      end
    end
  end

endmodule

// ===== hdl/ata_seq_queue.sv =====
// short job queue between front and back end
module ata_seq_queue import ata_seq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  job_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head         = slots_r[rd_ptr_r];
  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hdl/ata_seq_back.sv =====
// back end: expands queued jobs into bus results, one per cycle while the receiver is ready
module ata_seq_back import ata_seq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_bus_action,
  output logic [2:0]  out_register_select,
  output logic [7:0]  out_register_value,
  output logic [15:0] out_word_out,
  output logic [1:0]  out_completion_code,
  output logic        out_last
);

  logic [2:0]  step_r;
  logic        out_valid_r;
  act_t        act_r;
  reg_sel_t    sel_r;
  logic [7:0]  val_r;
  logic [15:0] word_r;
  cc_t         code_r;
  logic        last_r;

  act_t        res_act;
  reg_sel_t    res_sel;
  logic [7:0]  res_val;
  logic [15:0] res_word;
  cc_t         res_code;
  logic        res_last;
  logic        load;

  assign load = q_stat.valid && (!out_valid_r || out_ready);
  assign pop  = load && res_last;

  always_comb begin
    res_act  = ACT_POLL;
    res_sel  = REG_NONE;
    res_val  = '0;
    res_word = '0;
    res_code = CC_OK;
    res_last = 1'b1;
    unique case (head.kind)
      JOB_DONE: begin
        res_act  = ACT_DONE;
        res_code = head.code;
      end
      JOB_POLL: res_act = ACT_POLL;
      JOB_TASKFILE: begin
        res_act  = ACT_REG_WR;
        res_last = 1'b0;
        unique case (step_r)
          3'd0: begin
            res_sel = REG_DEVICE;
            res_val = {DEV_LBA_HI, head.lba[27:24]};
          end
          3'd1: begin
            res_sel = REG_LBA_HIGH;
            res_val = head.lba[23:16];
          end
          3'd2: begin
            res_sel = REG_LBA_MID;
            res_val = head.lba[15:8];
          end
          3'd3: begin
            res_sel = REG_LBA_LOW;
            res_val = head.lba[7:0];
          end
          3'd4: begin
            res_sel = REG_SEC_CNT;
            res_val = head.count;
          end
          3'd5: begin
            res_sel = REG_CMD;
            res_val = head.is_write ? OPC_WRITE_PIO : OPC_READ_PIO;
          end
          default: begin
            res_act  = ACT_POLL;
            res_last = 1'b1;
          end
        endcase
      end
      JOB_WORD: begin
        if (step_r == '0) begin
          res_act  = head.is_write ? ACT_TO_DEV : ACT_TO_HOST;
          res_word = head.word;
          res_last = (head.tail == TAIL_NONE);
        end else if (head.tail == TAIL_DONE) begin
          res_act = ACT_DONE;
        end else begin
          res_act = ACT_POLL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      step_r      <= res_last ? 3'd0 : step_r + 3'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r  <= res_act;
      sel_r  <= res_sel;
      val_r  <= res_val;
      word_r <= res_word;
      code_r <= res_code;
      last_r <= res_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_bus_action      = act_r;
  assign out_register_select = sel_r;
  assign out_register_value  = val_r;
  assign out_word_out        = word_r;
  assign out_completion_code = code_r;
  assign out_last            = last_r;

endmodule

// ===== tb/sv/ata_pio_sector_sequencer_tb.sv =====
`timescale 1ns / 1ps
// testbench of the ata pio sector sequencer: directed and random traffic, checked per result
module ata_pio_sector_sequencer_tb;
  import ata_seq_pkg::*;

  // operation codes the block has no use for
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  // cycles allowed for silent items still inside the block before a register write
  localparam int SETTLE_CYCLES = 12;
  // receiver hold-off that fills the job queue
  localparam int HOLD_CYCLES = 40;
  // words streamed into the held-off receiver
  localparam int STALL_WORDS = 16;
  localparam int REPORT_CAP = 200;
  localparam int ROUND_ITEMS = 8;

  // protocol phases as seen by the host
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WAIT_READY,
    SEQ_WAIT_DRQ,
    SEQ_XFER,
    SEQ_WAIT_FINISH
  } seq_phase_t;

  // one bus action as it leaves the block
  typedef struct packed {
    act_t        act;
    reg_sel_t    sel;
    logic [7:0]  val;
    logic [15:0] word;
    cc_t         code;
    logic        last;
  } bus_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_operation;
  logic [31:0]       in_sector_address;
  logic [8:0]        in_sector_count;
  logic [7:0]        in_status_byte;
  logic [15:0]       in_data_word;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        out_bus_action;
  logic [2:0]        out_register_select;
  logic [7:0]        out_register_value;
  logic [15:0]       out_word_out;
  logic [1:0]        out_completion_code;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [TICK_W-1:0] cfg_data;

  ata_pio_sector_sequencer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_sector_address   (in_sector_address),
    .in_sector_count     (in_sector_count),
    .in_status_byte      (in_status_byte),
    .in_data_word        (in_data_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bus_action      (out_bus_action),
    .out_register_select (out_register_select),
    .out_register_value  (out_register_value),
    .out_word_out        (out_word_out),
    .out_completion_code (out_completion_code),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // host-side view of the sequencer: protocol state and register copies
  seq_phase_t        seq_phase;
  logic              wr_cmd;
  logic [TICK_W-1:0] ticks_left;
  logic [8:0]        sectors_todo;
  int                word_pos;
  logic [LBA_W-1:0]  lba_held;
  logic [7:0]        count_byte;
  logic              dev_ready;
  logic [TICK_W-1:0] ready_budget;
  logic [TICK_W-1:0] drq_budget;
  logic [TICK_W-1:0] finish_budget;

  // bus actions owed by the block, oldest first
  bus_result_t bus_results_due[$];
  // actions caused by the item being predicted
  bus_result_t burst[$];

  int mismatches;
  int traffic_items;
  int hold_request;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[ata_pio_sector_sequencer] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void clear_sequencer();
    seq_phase     = SEQ_IDLE;
    wr_cmd        = 1'b0;
    ticks_left    = '0;
    sectors_todo  = '0;
    word_pos      = 0;
    lba_held      = '0;
    count_byte    = '0;
    dev_ready     = 1'b0;
    ready_budget  = 10'd100;
    drq_budget    = 10'd250;
    finish_budget = 10'd100;
  endfunction

  function automatic void emit(act_t a, reg_sel_t s, logic [7:0] v, logic [15:0] w, cc_t c);
    bus_result_t r;
    r.act  = a;
    r.sel  = s;
    r.val  = v;
    r.word = w;
    r.code = c;
    r.last = 1'b0;
    burst.push_back(r);
  endfunction

  // every status wait starts with a poll and a fresh tick budget
  function automatic void open_wait(seq_phase_t ph, logic [TICK_W-1:0] budget);
    seq_phase  = ph;
    ticks_left = budget;
    emit(ACT_POLL, REG_NONE, 8'h00, 16'h0000, CC_OK);
  endfunction

  function automatic void conclude(cc_t code);
    seq_phase = SEQ_IDLE;
    emit(ACT_DONE, REG_NONE, 8'h00, 16'h0000, code);
  endfunction

  // works out the bus actions of one accepted item and queues them
  function automatic void advance_sequencer(logic [2:0] op, logic [31:0] lba, logic [8:0] cnt,
                                            logic [7:0] st, logic [15:0] data);
    logic        met;
    bus_result_t r;
    burst.delete();
    if (op == OP_START_RD || op == OP_START_WR) begin
      // starts while busy are dropped
      if (seq_phase == SEQ_IDLE) begin
        if (cnt == 0 || cnt > MAX_SECTORS || lba[31:LBA_W] != 0) begin
          conclude(CC_PARAM);
        end else if (!dev_ready) begin
          conclude(CC_NOT_READY);
        end else begin
          wr_cmd       = (op == OP_START_WR);
          lba_held     = lba[LBA_W-1:0];
          count_byte   = cnt[7:0];
          sectors_todo = cnt;
          word_pos     = 0;
          open_wait(SEQ_WAIT_READY, ready_budget);
        end
      end
    end else if (op == OP_STATUS) begin
      if (seq_phase == SEQ_WAIT_READY || seq_phase == SEQ_WAIT_DRQ ||
          seq_phase == SEQ_WAIT_FINISH) begin
        if (ticks_left == 0 || st[ST_ERR]) begin
          // spent budget or device error
          conclude(CC_FAULT);
        end else begin
          if (seq_phase == SEQ_WAIT_READY) met = !st[ST_BSY] && st[ST_DRDY];
          else if (seq_phase == SEQ_WAIT_DRQ) met = !st[ST_BSY] && st[ST_DRQ];
          else met = !st[ST_BSY];
          if (!met) begin
            emit(ACT_POLL, REG_NONE, 8'h00, 16'h0000, CC_OK);
          end else if (seq_phase == SEQ_WAIT_READY) begin
            // task file, command, then the first drq wait
            emit(ACT_REG_WR, REG_DEVICE, {DEV_LBA_HI, lba_held[LBA_W-1:LBA_W-4]},
                 16'h0000, CC_OK);
            emit(ACT_REG_WR, REG_LBA_HIGH, lba_held[23:16], 16'h0000, CC_OK);
            emit(ACT_REG_WR, REG_LBA_MID, lba_held[15:8], 16'h0000, CC_OK);
            emit(ACT_REG_WR, REG_LBA_LOW, lba_held[7:0], 16'h0000, CC_OK);
            emit(ACT_REG_WR, REG_SEC_CNT, count_byte, 16'h0000, CC_OK);
            emit(ACT_REG_WR, REG_CMD, wr_cmd ? OPC_WRITE_PIO : OPC_READ_PIO, 16'h0000, CC_OK);
            open_wait(SEQ_WAIT_DRQ, drq_budget);
          end else if (seq_phase == SEQ_WAIT_DRQ) begin
            seq_phase = SEQ_XFER;
            word_pos  = 0;
          end else begin
            conclude(CC_OK);
          end
        end
      end
    end else if (op == OP_RD_WORD || op == OP_WR_WORD) begin
      // only words of the command's direction during a transfer count
      if (seq_phase == SEQ_XFER && wr_cmd == (op == OP_WR_WORD)) begin
        if (wr_cmd) emit(ACT_TO_DEV, REG_NONE, 8'h00, data, CC_OK);
        else emit(ACT_TO_HOST, REG_NONE, 8'h00, data, CC_OK);
        word_pos++;
        if (word_pos >= SECTOR_WORDS) begin
          word_pos     = 0;
          sectors_todo = sectors_todo - 9'd1;
          if (sectors_todo != 0) open_wait(SEQ_WAIT_DRQ, drq_budget);
          else if (wr_cmd) open_wait(SEQ_WAIT_FINISH, finish_budget);
          else conclude(CC_OK);
        end
      end
    end else if (op == OP_TICK) begin
      // counts down in any phase, sticks at zero
      if (ticks_left != 0) ticks_left--;
    end
    for (int k = 0; k < burst.size(); k++) begin
      r      = burst[k];
      r.last = (k == burst.size() - 1);
      bus_results_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- driving

  // offers one item, holds it until taken, then predicts its effect
  task automatic push_item(logic [2:0] op, logic [31:0] lba, logic [8:0] cnt,
                           logic [7:0] st, logic [15:0] data);
    if (!steady && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_sector_address <= lba;
    in_sector_count   <= cnt;
    in_status_byte    <= st;
    in_data_word      <= data;
    do @(posedge clk); while (in_ready !== 1'b1);
    advance_sequencer(op, lba, cnt, st, data);
  endtask

  // one operation with random filler in every field
  task automatic push_op(logic [2:0] op);
    push_item(op, $urandom, 9'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // one status sample with random filler elsewhere
  task automatic push_status(logic [7:0] st);
    push_item(OP_STATUS, $urandom, 9'($urandom), st, 16'($urandom));
  endtask

  // sender stops until every owed action has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (bus_results_due.size() != 0);
  endtask

  // write channel stays high across back-to-back writes
  task automatic write_register(cfg_idx_t idx, logic [TICK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_DEV_READY: dev_ready = value[0];
      CFG_READY_TO:  ready_budget = value;
      CFG_XFER_TO:   drq_budget = value;
      CFG_FINISH_TO: finish_budget = value;
    endcase
  endtask

  // all four registers, only once the block has gone quiet
  task automatic configure(logic rdy, logic [TICK_W-1:0] ready_to, logic [TICK_W-1:0] xfer_to,
                           logic [TICK_W-1:0] finish_to);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(CFG_DEV_READY, {{(TICK_W-1){1'b0}}, rdy});
    write_register(CFG_READY_TO, ready_to);
    write_register(CFG_XFER_TO, xfer_to);
    write_register(CFG_FINISH_TO, finish_to);
    cfg_valid <= 1'b0;
  endtask

  // status byte that meets, or misses, the condition of the current wait
  function automatic logic [7:0] sample_status(bit satisfy);
    logic [7:0] st;
    st         = 8'($urandom);
    st[ST_ERR] = 1'b0;
    if (satisfy) begin
      st[ST_BSY] = 1'b0;
      if (seq_phase == SEQ_WAIT_READY) st[ST_DRDY] = 1'b1;
      if (seq_phase == SEQ_WAIT_DRQ) st[ST_DRQ] = 1'b1;
    end else if (seq_phase == SEQ_WAIT_FINISH || $urandom_range(0, 1)) begin
      st[ST_BSY] = 1'b1;
    end else if (seq_phase == SEQ_WAIT_READY) begin
      st[ST_DRDY] = 1'b0;
    end else begin
      st[ST_DRQ] = 1'b0;
    end
    return st;
  endfunction

  // items the block should drop in the current phase
  task automatic push_noise();
    case ($urandom_range(0, 3))
      0: push_op($urandom_range(0, 1) ? OP_START_WR : OP_START_RD);
      1: push_op($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6);
      2: push_op(wr_cmd ? OP_RD_WORD : OP_WR_WORD);
      default: begin
        if (seq_phase == SEQ_XFER) push_op(OP_STATUS);
        else push_op(OP_SPARE_6);
      end
    endcase
  endtask

  // one command up to its task file and drq wait, ended by err or timeout unless the start is rejected
  task automatic run_command(logic wr, logic [8:0] sectors, logic [31:0] lba);
    int         pick;
    logic [7:0] st;
    push_item(wr ? OP_START_WR : OP_START_RD, lba, sectors, 8'($urandom), 16'($urandom));
    traffic_items++;
    while (seq_phase != SEQ_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick < 25 || (seq_phase == SEQ_WAIT_DRQ && pick < 40)) begin
        // run the budget dry when cheap, otherwise flag a device error
        if (ticks_left <= 8 && $urandom_range(0, 1)) begin
          while (ticks_left != 0) begin
            push_op(OP_TICK);
            traffic_items++;
          end
        end
        st = 8'($urandom);
        if (ticks_left != 0) st[ST_ERR] = 1'b1;
        push_status(st);
        traffic_items++;
      end else if (pick < 45 && ticks_left > 1) begin
        push_op(OP_TICK);
        traffic_items++;
      end else if (pick < 70) begin
        push_status(sample_status(1'b0));
        traffic_items++;
      end else if (pick < 80) begin
        push_noise();
      end else if (seq_phase == SEQ_WAIT_READY) begin
        push_status(sample_status(1'b1));
        traffic_items++;
      end else begin
        push_status(sample_status(1'b0));
        traffic_items++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // bad counts, out-of-range addresses, then a good start on an unready drive
  task automatic test_rejected_starts();
    push_item(OP_START_RD, 32'h0000_0000, 9'd0, 8'h00, 16'h0000);
    push_item(OP_START_WR, 32'h0000_0001, 9'd257, 8'hFF, 16'hFFFF);
    push_item(OP_START_RD, 32'h0000_0000, 9'd511, 8'h00, 16'h0000);
    push_item(OP_START_WR, 32'h1000_0000, 9'd1, 8'hFF, 16'hFFFF);
    push_item(OP_START_RD, 32'hFFFF_FFFF, 9'd256, 8'h00, 16'h0000);
    push_item(OP_START_WR, 32'h0FFF_FFFF, 9'd256, 8'hFF, 16'hFFFF);
  endtask

  // everything that should leave an idle block silent
  task automatic test_idle_items();
    push_item(OP_STATUS, 32'hFFFF_FFFF, 9'd511, 8'hFF, 16'hFFFF);
    push_item(OP_RD_WORD, 32'h0000_0000, 9'd0, 8'h00, 16'hFFFF);
    push_item(OP_WR_WORD, 32'hFFFF_FFFF, 9'd511, 8'hFF, 16'h0000);
    push_item(OP_TICK, 32'h0000_0000, 9'd0, 8'h00, 16'h0000);
    push_item(OP_SPARE_6, 32'hFFFF_FFFF, 9'd511, 8'hFF, 16'hFFFF);
    push_item(OP_SPARE_7, 32'h0000_0000, 9'd0, 8'h00, 16'h0000);
  endtask

  // one-tick ready budget ticked to zero, so a good sample still times out
  task automatic test_ready_timeout();
    push_item(OP_START_RD, 32'h0000_0000, 9'd1, 8'h00, 16'h0000);
    push_item(OP_TICK, 32'h0000_0000, 9'd0, 8'h00, 16'h0000);
    push_item(OP_STATUS, 32'h0000_0000, 9'd0, 8'h40, 16'h0000);
  endtask

  // busy and not-ready polls, start while busy, full task file, err during drq wait
  task automatic test_task_file_and_abort();
    push_item(OP_START_WR, 32'h0FFF_FFFF, 9'd256, 8'h00, 16'h0000);
    push_item(OP_STATUS, 32'h0000_0000, 9'd0, 8'hC0, 16'h0000);
    push_item(OP_STATUS, 32'h0000_0000, 9'd0, 8'h00, 16'h0000);
    push_item(OP_START_RD, 32'h0000_0000, 9'd1, 8'h00, 16'h0000);
    push_item(OP_STATUS, 32'h0000_0000, 9'd0, 8'h40, 16'h0000);
    push_item(OP_STATUS, 32'h0000_0000, 9'd0, 8'h09, 16'h0000);
  endtask

  // one written sector with a full pause half way, then the closing busy wait
  task automatic test_paced_write();
    push_item(OP_START_WR, $urandom_range(0, 32'h0FFF_FFFF), 9'd1, 8'($urandom),
              16'($urandom));
    push_status(sample_status(1'b1));
    push_status(sample_status(1'b0));
    push_status(sample_status(1'b1));
    // long stretch without idling on either side
    steady = 1'b1;
    for (int k = 0; k < SECTOR_WORDS / 2; k++)
      push_op(OP_WR_WORD);
    steady = 1'b0;
    wait_drained();
    for (int k = SECTOR_WORDS / 2; k < SECTOR_WORDS; k++)
      push_op(OP_WR_WORD);
    push_status(sample_status(1'b0));
    push_status(sample_status(1'b1));
  endtask

  // read words streamed while the receiver holds off, so the block backs up;
  // the sector is left unfinished and the run ends inside the transfer
  task automatic test_output_stall();
    push_item(OP_START_RD, $urandom_range(0, 32'h0FFF_FFFF), 9'd2, 8'($urandom),
              16'($urandom));
    push_status(sample_status(1'b1));
    push_status(sample_status(1'b1));
    steady       = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < STALL_WORDS; k++)
      push_op(OP_RD_WORD);
    push_noise();
    push_op(OP_RD_WORD);
    steady = 1'b0;
  endtask

  // mixed commands: rejected starts, idle chatter, aborted commands
  task automatic run_traffic_round(int budget);
    int          goal;
    logic [31:0] lba;
    logic [8:0]  cnt;
    goal = traffic_items + budget;
    while (traffic_items < goal) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          lba = $urandom;
          cnt = 9'($urandom_range(1, MAX_SECTORS));
          case ($urandom_range(0, 2))
            0: cnt = 9'd0;
            1: cnt = 9'($urandom_range(MAX_SECTORS + 1, 511));
            default: lba[31:LBA_W] = 4'($urandom_range(1, 15));
          endcase
          push_item($urandom_range(0, 1) ? OP_START_WR : OP_START_RD, lba, cnt,
                    8'($urandom), 16'($urandom));
          traffic_items++;
        end
        2: begin
          push_op(3'($urandom_range(2, 7)));
          traffic_items++;
        end
        default: run_command(1'($urandom_range(0, 1)), 9'($urandom_range(1, MAX_SECTORS)),
                             $urandom_range(0, 32'h0FFF_FFFF));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 4; round++) begin
      case (round)
        0: configure(1'b1, 10'($urandom_range(1, 30)), 10'd1, 10'd1023);
        1: configure(1'b1, 10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                     10'($urandom_range(1, 40)));
        2: configure(1'b0, 10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                     10'($urandom_range(1, 40)));
        default: configure(1'b1, 10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                           10'($urandom_range(1, 1023)));
      endcase
      run_traffic_round(ROUND_ITEMS);
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  // every taken result against the oldest owed one
  initial begin
    bus_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (bus_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected result, expected none got action %0d word %0h",
                     $time, out_bus_action, out_word_out);
        end else begin
          want = bus_results_due.pop_front();
          check_field("bus_action", 16'(want.act), 16'(out_bus_action));
          check_field("register_select", 16'(want.sel), 16'(out_register_select));
          check_field("register_value", 16'(want.val), 16'(out_register_value));
          check_field("word_out", want.word, out_word_out);
          check_field("completion_code", 16'(want.code), 16'(out_completion_code));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is asked for
  initial begin
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        n            = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    mismatches    = 0;
    traffic_items = 0;
    hold_request  = 0;
    steady        = 1'b0;
    clear_sequencer();
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_operation      <= '0;
    in_sector_address <= '0;
    in_sector_count   <= '0;
    in_status_byte    <= '0;
    in_data_word      <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_DEV_READY;
    cfg_data          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values first: drive not ready
    test_rejected_starts();
    test_idle_items();
    configure(1'b1, 10'd1, 10'd1023, 10'd1);
    test_ready_timeout();
    configure(1'b1, 10'd1023, 10'd1023, 10'd1);
    test_task_file_and_abort();
    test_paced_write();
    test_random_traffic();
    configure(1'b1, 10'd1023, 10'd1023, 10'd1);
    test_output_stall();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && bus_results_due.size() == 0) begin
      $display("[ata_pio_sector_sequencer] OK");
    end else begin
      $display("[ata_pio_sector_sequencer] ERROR");
    end
    $finish;
  end

endmodule
